FILE: rtl/core/crtc_centering_timing_adjust_core_macros.svh
// Assertion macros for the CRTC centering core.
// Used by crtc_centering_timing_adjust_core; needs no other file.
`ifndef CRTC_CENTERING_TIMING_ADJUST_CORE_MACROS_SVH
`define CRTC_CENTERING_TIMING_ADJUST_CORE_MACROS_SVH

// same-cycle implication
`define CRTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crtc core assertion failed");

// next-cycle implication
`define CRTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crtc core assertion failed");

`endif

FILE: rtl/core/crtc_adj_pkg.sv
// Package for the CRTC centering core: constants, reset values, state and result types.
// No dependencies.
`default_nettype none

package crtc_adj_pkg;

  localparam logic [7:0] H_DISP_END   = 8'h4f;
  localparam logic [7:0] V_DISP_END   = 8'hef;
  localparam logic [7:0] H_BLANK_END  = 8'(((H_DISP_END + 8'd3) & 8'h1f) | 8'h80);
  localparam logic [7:0] H_RETR_ADD   = 8'd11;

  localparam logic [4:0] CENTER_X_MAX = 5'd16;
  localparam logic [4:0] CENTER_X_MID = 5'd8;
  localparam logic [3:0] CENTER_Y_MAX = 4'd8;
  localparam logic [3:0] CENTER_Y_MID = 4'd4;

  // overflow register bit positions
  localparam int OVF_VTOT8 = 0;
  localparam int OVF_VDE8  = 1;
  localparam int OVF_VRS8  = 2;
  localparam int OVF_VBS8  = 3;
  localparam int OVF_VTOT9 = 5;
  localparam int OVF_VDE9  = 6;
  localparam int OVF_VRS9  = 7;
  // max scanline bit holding vblank start bit 9
  localparam int MSL_VBS9  = 5;

  typedef struct packed {
    logic [7:0] h_rstart;
    logic [7:0] v_rstart;
    logic [7:0] v_rend;
    logic [7:0] ovf;
    logic [7:0] msl;
    logic [7:0] v_bstart;
    logic [7:0] v_bend;
  } crtc_state_t;

  localparam crtc_state_t STATE_RESET = '{
    h_rstart: 8'h55,
    v_rstart: 8'hf2,
    v_rend:   8'ha4,
    ovf:      8'h11,
    msl:      8'h40,
    v_bstart: 8'hf0,
    v_bend:   8'hf2
  };

  typedef struct packed {
    logic [7:0] h_total_reg;
    logic [7:0] v_total_reg;
    logic [7:0] h_retrace_start_reg;
    logic [7:0] h_retrace_end_reg;
    logic [7:0] h_blank_start_reg;
    logic [7:0] h_blank_end_reg;
    logic [7:0] v_retrace_start_reg;
    logic [7:0] v_retrace_end_reg;
    logic [7:0] overflow_reg;
    logic [7:0] max_scanline_reg;
    logic [7:0] v_blank_start_reg;
    logic [7:0] v_blank_end_reg;
  } crtc_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/crtc_adj_if.sv
// Valid/ready channel interfaces for request and result transactions.
// No dependencies.
`default_nettype none

interface crtc_adj_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] h_total_value;
  logic [7:0] v_total_value;
  logic [4:0] center_x_pos;
  logic [3:0] center_y_pos;

  modport source (output valid, h_total_value, v_total_value, center_x_pos, center_y_pos,
                  input ready);
  modport sink (input valid, h_total_value, v_total_value, center_x_pos, center_y_pos,
                output ready);
endinterface

interface crtc_adj_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] h_total_reg;
  logic [7:0] v_total_reg;
  logic [7:0] h_retrace_start_reg;
  logic [7:0] h_retrace_end_reg;
  logic [7:0] h_blank_start_reg;
  logic [7:0] h_blank_end_reg;
  logic [7:0] v_retrace_start_reg;
  logic [7:0] v_retrace_end_reg;
  logic [7:0] overflow_reg;
  logic [7:0] max_scanline_reg;
  logic [7:0] v_blank_start_reg;
  logic [7:0] v_blank_end_reg;

  modport source (output valid, h_total_reg, v_total_reg, h_retrace_start_reg,
                  h_retrace_end_reg, h_blank_start_reg, h_blank_end_reg,
                  v_retrace_start_reg, v_retrace_end_reg, overflow_reg,
                  max_scanline_reg, v_blank_start_reg, v_blank_end_reg,
                  input ready);
  modport sink (input valid, h_total_reg, v_total_reg, h_retrace_start_reg,
                h_retrace_end_reg, h_blank_start_reg, h_blank_end_reg,
                v_retrace_start_reg, v_retrace_end_reg, overflow_reg,
                max_scanline_reg, v_blank_start_reg, v_blank_end_reg,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/core/crtc_centering_timing_adjust_core.sv
// CRTC centering core: each accepted request transaction is written straight into the result register.
// Throughput 1 transaction per cycle while the receiver takes results; the timing state register feeds back through
// one combinational update, and the result register refills while its result is taken.
// Reset (rst_n low, synchronous) restores the 320x240 timing table and empties the output.
// Depends on crtc_adj_pkg, crtc_adj_if, crtc_adj_calc and the macros header.
`default_nettype none

`include "crtc_centering_timing_adjust_core_macros.svh"

module crtc_centering_timing_adjust_core (
  input  wire             clk,
  input  wire             rst_n,
  crtc_adj_in_if.sink     in_ch,
  crtc_adj_out_if.source  out_ch
);

  crtc_adj_pkg::crtc_state_t  state_r;
  crtc_adj_pkg::crtc_state_t  state_nxt;
  crtc_adj_pkg::crtc_result_t result_r;
  crtc_adj_pkg::crtc_result_t result_nxt;
  logic                       out_valid_r;
  logic                       in_ready;
  logic                       in_accept;

  assign in_ready  = !out_valid_r || out_ch.ready;
  assign in_accept = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  crtc_adj_calc u_calc (
    .state_i    (state_r),
    .h_total_i  (in_ch.h_total_value),
    .v_total_i  (in_ch.v_total_value),
    .center_x_i (in_ch.center_x_pos),
    .center_y_i (in_ch.center_y_pos),
    .state_o    (state_nxt),
    .result_o   (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crtc_adj_pkg::STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.h_total_reg         = result_r.h_total_reg;
  assign out_ch.v_total_reg         = result_r.v_total_reg;
  assign out_ch.h_retrace_start_reg = result_r.h_retrace_start_reg;
  assign out_ch.h_retrace_end_reg   = result_r.h_retrace_end_reg;
  assign out_ch.h_blank_start_reg   = result_r.h_blank_start_reg;
  assign out_ch.h_blank_end_reg     = result_r.h_blank_end_reg;
  assign out_ch.v_retrace_start_reg = result_r.v_retrace_start_reg;
  assign out_ch.v_retrace_end_reg   = result_r.v_retrace_end_reg;
  assign out_ch.overflow_reg        = result_r.overflow_reg;
  assign out_ch.max_scanline_reg    = result_r.max_scanline_reg;
  assign out_ch.v_blank_start_reg   = result_r.v_blank_start_reg;
  assign out_ch.v_blank_end_reg     = result_r.v_blank_end_reg;

  // accepted transaction always lands in the result register
  `CRTC_ASSERT_NXT(a_accept_fills, clk, rst_n, in_accept, out_valid_r)
  // timing state only moves on an accepted transaction
  `CRTC_ASSERT_NXT(a_state_hold, clk, rst_n, !in_accept, $stable(state_r))
  // vblank start never past vertical total
  `CRTC_ASSERT_IMP(a_vbs_le_vtot, clk, rst_n, out_valid_r,
    {result_r.max_scanline_reg[crtc_adj_pkg::MSL_VBS9],
     result_r.overflow_reg[crtc_adj_pkg::OVF_VBS8], result_r.v_blank_start_reg} <=
    {result_r.overflow_reg[crtc_adj_pkg::OVF_VTOT9],
     result_r.overflow_reg[crtc_adj_pkg::OVF_VTOT8], result_r.v_total_reg})
  // result holds while the receiver stalls
  `CRTC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid_r && !out_ch.ready,
    out_valid_r && $stable(result_r))

endmodule

`default_nettype wire

FILE: rtl/core/crtc_adj_calc.sv
// Combinational timing update: shifts and clamps retrace/blanking for one request.
// Depends on crtc_adj_pkg.
`default_nettype none

module crtc_adj_calc (
  input  crtc_adj_pkg::crtc_state_t  state_i,
  input  logic [7:0]                 h_total_i,
  input  logic [7:0]                 v_total_i,
  input  logic [4:0]                 center_x_i,
  input  logic [3:0]                 center_y_i,
  output crtc_adj_pkg::crtc_state_t  state_o,
  output crtc_adj_pkg::crtc_result_t result_o
);

  typedef logic signed [11:0] sval_t;

  always_comb begin
    logic [4:0] cx_sat;
    logic [3:0] cy_sat;
    sval_t      dx;
    sval_t      dy;
    sval_t      hrs;
    sval_t      hrs_end;
    sval_t      vrs;
    sval_t      vrw;
    sval_t      vdisp;
    sval_t      vtot;
    sval_t      vr_end;
    sval_t      vbs;
    sval_t      vbw;
    sval_t      vb_end;
    logic [7:0] ovf_n;
    logic [7:0] msl_n;

    cx_sat = (center_x_i > crtc_adj_pkg::CENTER_X_MAX) ? crtc_adj_pkg::CENTER_X_MAX : center_x_i;
    cy_sat = (center_y_i > crtc_adj_pkg::CENTER_Y_MAX) ? crtc_adj_pkg::CENTER_Y_MAX : center_y_i;
    dx = $signed({7'b0, cx_sat}) - $signed({7'b0, crtc_adj_pkg::CENTER_X_MID});
    dy = $signed({8'b0, cy_sat}) - $signed({8'b0, crtc_adj_pkg::CENTER_Y_MID});

    // horizontal retrace, kept past display end
    hrs = $signed({4'b0, state_i.h_rstart}) + dx;
    if (hrs <= $signed({4'b0, crtc_adj_pkg::H_DISP_END})) begin
      hrs = $signed({4'b0, crtc_adj_pkg::H_DISP_END}) + 12'sd1;
    end
    hrs_end = hrs + $signed({4'b0, crtc_adj_pkg::H_RETR_ADD});

    vdisp = $signed({2'b0, state_i.ovf[crtc_adj_pkg::OVF_VDE9],
                     state_i.ovf[crtc_adj_pkg::OVF_VDE8], crtc_adj_pkg::V_DISP_END}) + 12'sd1;
    vtot  = $signed({2'b0, state_i.ovf[crtc_adj_pkg::OVF_VTOT9],
                     state_i.ovf[crtc_adj_pkg::OVF_VTOT8], v_total_i});

    // vertical retrace
    vrs = $signed({2'b0, state_i.ovf[crtc_adj_pkg::OVF_VRS9],
                   state_i.ovf[crtc_adj_pkg::OVF_VRS8], state_i.v_rstart});
    vrw = $signed({8'b0, state_i.v_rend[3:0]}) - $signed({8'b0, state_i.v_rstart[3:0]});
    vrs = vrs + dy;
    if (vrs < vdisp) begin
      vrs = vdisp;
    end
    vr_end = vrs + vrw;
    if (vr_end > vtot) begin
      vr_end = vtot;
    end

    ovf_n = state_i.ovf;
    ovf_n[crtc_adj_pkg::OVF_VRS8] = vrs[8];
    ovf_n[crtc_adj_pkg::OVF_VRS9] = vrs[9];

    // vertical blanking
    vbs = $signed({2'b0, state_i.msl[crtc_adj_pkg::MSL_VBS9],
                   state_i.ovf[crtc_adj_pkg::OVF_VBS8], state_i.v_bstart});
    vbw = $signed({4'b0, state_i.v_bend}) - $signed({4'b0, state_i.v_bstart});
    vbs = vbs + dy;
    if (vbs < vdisp) begin
      vbs = vdisp;
    end
    if (vbs > vtot) begin
      vbs = vtot;
    end
    vb_end = vbs + vbw;
    if (vb_end > vtot) begin
      vb_end = vtot;
    end

    ovf_n[crtc_adj_pkg::OVF_VBS8] = vbs[8];
    msl_n = state_i.msl;
    msl_n[crtc_adj_pkg::MSL_VBS9] = vbs[9];

    state_o.h_rstart = hrs[7:0];
    state_o.v_rstart = vrs[7:0];
    state_o.v_rend   = {state_i.v_rend[7:4], vr_end[3:0]};
    state_o.ovf      = ovf_n;
    state_o.msl      = msl_n;
    state_o.v_bstart = vbs[7:0];
    state_o.v_bend   = vb_end[7:0];

    result_o.h_total_reg         = h_total_i;
    result_o.v_total_reg         = v_total_i;
    result_o.h_retrace_start_reg = hrs[7:0];
    result_o.h_retrace_end_reg   = {3'b0, hrs_end[4:0]};
    result_o.h_blank_start_reg   = crtc_adj_pkg::H_DISP_END;
    result_o.h_blank_end_reg     = crtc_adj_pkg::H_BLANK_END;
    result_o.v_retrace_start_reg = vrs[7:0];
    result_o.v_retrace_end_reg   = {state_i.v_rend[7:4], vr_end[3:0]};
    result_o.overflow_reg        = ovf_n;
    result_o.max_scanline_reg    = msl_n;
    result_o.v_blank_start_reg   = vbs[7:0];
    result_o.v_blank_end_reg     = vb_end[7:0];
  end

endmodule

`default_nettype wire

FILE: tb/crtc_centering_timing_adjust_core_tb.sv
// Testbench for crtc_centering_timing_adjust_core: drives centering requests, predicts the
// CRTC register bytes with its own timing table, and checks every result transaction.
// Depends on crtc_adj_pkg, crtc_adj_in_if/crtc_adj_out_if and the core RTL.
`default_nettype none

module crtc_centering_timing_adjust_core_tb;

  localparam int NUM_REQUESTS = 1250;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [7:0] h_total_value;
    logic [7:0] v_total_value;
    logic [4:0] center_x_pos;
    logic [3:0] center_y_pos;
  } request_t;

  typedef enum int {SHIFT_ANY, SHIFT_UP, SHIFT_DOWN} shift_mode_t;

  class crtc_timing_scoreboard;
    crtc_adj_pkg::crtc_state_t  timing;
    crtc_adj_pkg::crtc_result_t expected_regs[$];
    int                         errors;

    function new();
      timing = crtc_adj_pkg::STATE_RESET;
      errors = 0;
    endfunction

    function int pending();
      return expected_regs.size();
    endfunction

    // Accepted request: advance the timing table and queue the register bytes.
    function void note_request(request_t req);
      int cx, cy, dx, dy, hrs, vrs, vrw, vdisp, vtot, vbs, vbw, span;
      crtc_adj_pkg::crtc_result_t r;
      cx = (req.center_x_pos > crtc_adj_pkg::CENTER_X_MAX) ?
           int'(crtc_adj_pkg::CENTER_X_MAX) : int'(req.center_x_pos);
      cy = (req.center_y_pos > crtc_adj_pkg::CENTER_Y_MAX) ?
           int'(crtc_adj_pkg::CENTER_Y_MAX) : int'(req.center_y_pos);
      dx = cx - int'(crtc_adj_pkg::CENTER_X_MID);
      dy = cy - int'(crtc_adj_pkg::CENTER_Y_MID);

      hrs = int'(timing.h_rstart) + dx;
      if (hrs <= int'(crtc_adj_pkg::H_DISP_END)) hrs = int'(crtc_adj_pkg::H_DISP_END) + 1;
      timing.h_rstart = hrs[7:0];
      span = hrs + int'(crtc_adj_pkg::H_RETR_ADD);
      r.h_retrace_end_reg = {3'b000, span[4:0]};
      span = int'(crtc_adj_pkg::H_DISP_END) + 3;
      r.h_blank_end_reg = {3'b100, span[4:0]};

      vrs = {timing.ovf[crtc_adj_pkg::OVF_VRS9], timing.ovf[crtc_adj_pkg::OVF_VRS8],
             timing.v_rstart};
      vrw = int'(timing.v_rend[3:0]) - (vrs & 15);
      vrs = vrs + dy;
      vdisp = {timing.ovf[crtc_adj_pkg::OVF_VDE9], timing.ovf[crtc_adj_pkg::OVF_VDE8],
               crtc_adj_pkg::V_DISP_END};
      vdisp = vdisp + 1;
      if (vrs < vdisp) vrs = vdisp;
      vtot = {timing.ovf[crtc_adj_pkg::OVF_VTOT9], timing.ovf[crtc_adj_pkg::OVF_VTOT8],
              req.v_total_value};
      timing.v_rstart = vrs[7:0];
      timing.ovf[crtc_adj_pkg::OVF_VRS8] = vrs[8];
      timing.ovf[crtc_adj_pkg::OVF_VRS9] = vrs[9];
      span = vrs + vrw;
      if (span > vtot) span = vtot;
      timing.v_rend[3:0] = span[3:0];

      vbs = {timing.msl[crtc_adj_pkg::MSL_VBS9], timing.ovf[crtc_adj_pkg::OVF_VBS8],
             timing.v_bstart};
      vbw = int'(timing.v_bend) - (vbs & 255);
      vbs = vbs + dy;
      if (vbs < vdisp) vbs = vdisp;
      if (vbs > vtot) vbs = vtot;
      timing.v_bstart = vbs[7:0];
      timing.ovf[crtc_adj_pkg::OVF_VBS8] = vbs[8];
      timing.msl[crtc_adj_pkg::MSL_VBS9] = vbs[9];
      span = vbs + vbw;
      if (span > vtot) span = vtot;
      timing.v_bend = span[7:0];

      r.h_total_reg         = req.h_total_value;
      r.v_total_reg         = req.v_total_value;
      r.h_retrace_start_reg = timing.h_rstart;
      r.h_blank_start_reg   = crtc_adj_pkg::H_DISP_END;
      r.v_retrace_start_reg = timing.v_rstart;
      r.v_retrace_end_reg   = timing.v_rend;
      r.overflow_reg        = timing.ovf;
      r.max_scanline_reg    = timing.msl;
      r.v_blank_start_reg   = timing.v_bstart;
      r.v_blank_end_reg     = timing.v_bend;
      expected_regs.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s mismatch: expected 0x%02h, actual 0x%02h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(crtc_adj_pkg::crtc_result_t got);
      crtc_adj_pkg::crtc_result_t e;
      if (expected_regs.size() == 0) begin
        $error("result transaction with no request outstanding");
        errors++;
        return;
      end
      e = expected_regs.pop_front();
      compare_field("h_total_reg", e.h_total_reg, got.h_total_reg);
      compare_field("v_total_reg", e.v_total_reg, got.v_total_reg);
      compare_field("h_retrace_start_reg", e.h_retrace_start_reg, got.h_retrace_start_reg);
      compare_field("h_retrace_end_reg", e.h_retrace_end_reg, got.h_retrace_end_reg);
      compare_field("h_blank_start_reg", e.h_blank_start_reg, got.h_blank_start_reg);
      compare_field("h_blank_end_reg", e.h_blank_end_reg, got.h_blank_end_reg);
      compare_field("v_retrace_start_reg", e.v_retrace_start_reg, got.v_retrace_start_reg);
      compare_field("v_retrace_end_reg", e.v_retrace_end_reg, got.v_retrace_end_reg);
      compare_field("overflow_reg", e.overflow_reg, got.overflow_reg);
      compare_field("max_scanline_reg", e.max_scanline_reg, got.max_scanline_reg);
      compare_field("v_blank_start_reg", e.v_blank_start_reg, got.v_blank_start_reg);
      compare_field("v_blank_end_reg", e.v_blank_end_reg, got.v_blank_end_reg);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  crtc_adj_in_if  in_ch();
  crtc_adj_out_if out_ch();

  crtc_centering_timing_adjust_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  crtc_timing_scoreboard sb = new();
  int  requests_sent;
  int  results_taken;
  int  idle_cycles;
  bit  send_burst;
  bit  take_burst;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Burst stretches have no gaps; otherwise each transaction draws a fresh random wait.
  function automatic int draw_gap(ref bit burst);
    if ($urandom_range(0, 39) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic send_request(request_t req);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.h_total_value <= req.h_total_value;
    in_ch.v_total_value <= req.v_total_value;
    in_ch.center_x_pos  <= req.center_x_pos;
    in_ch.center_y_pos  <= req.center_y_pos;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(req);
    requests_sent++;
  endtask

  task automatic send_fields(logic [7:0] h, logic [7:0] v, logic [4:0] x, logic [3:0] y);
    request_t req;
    req = '{h_total_value: h, v_total_value: v, center_x_pos: x, center_y_pos: y};
    send_request(req);
  endtask

  function automatic request_t make_request(shift_mode_t mode);
    request_t req;
    req.h_total_value = 8'($urandom);
    req.v_total_value = 8'($urandom);
    case (mode)
      SHIFT_UP: begin
        req.center_x_pos = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                                       : 5'($urandom_range(10, 16));
        req.center_y_pos = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                                       : 4'($urandom_range(5, 8));
      end
      SHIFT_DOWN: begin
        req.center_x_pos = 5'($urandom_range(0, 6));
        req.center_y_pos = 4'($urandom_range(0, 3));
      end
      default: begin
        req.center_x_pos = 5'($urandom);
        req.center_y_pos = 4'($urandom);
      end
    endcase
    return req;
  endfunction

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result side, with one long hold-off so the core backs up into its input.
  initial begin : result_side
    crtc_adj_pkg::crtc_result_t got;
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = (results_taken == HOLD_AFTER) ? HOLD_CYCLES : draw_gap(take_burst);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.h_total_reg         = out_ch.h_total_reg;
      got.v_total_reg         = out_ch.v_total_reg;
      got.h_retrace_start_reg = out_ch.h_retrace_start_reg;
      got.h_retrace_end_reg   = out_ch.h_retrace_end_reg;
      got.h_blank_start_reg   = out_ch.h_blank_start_reg;
      got.h_blank_end_reg     = out_ch.h_blank_end_reg;
      got.v_retrace_start_reg = out_ch.v_retrace_start_reg;
      got.v_retrace_end_reg   = out_ch.v_retrace_end_reg;
      got.overflow_reg        = out_ch.overflow_reg;
      got.max_scanline_reg    = out_ch.max_scanline_reg;
      got.v_blank_start_reg   = out_ch.v_blank_start_reg;
      got.v_blank_end_reg     = out_ch.v_blank_end_reg;
      sb.check_result(got);
      results_taken++;
    end
  end

  initial begin : request_side
    shift_mode_t mode;
    int seg_len;
    bit long_done;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.h_total_value <= '0;
    in_ch.v_total_value <= '0;
    in_ch.center_x_pos  <= '0;
    in_ch.center_y_pos  <= '0;
    requests_sent = 0;
    results_taken = 0;
    idle_cycles   = 0;
    send_burst    = 1'b0;
    take_burst    = 1'b1;
    long_done     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: neutral, field extremes, saturation, clamps at display end and vtotal
    send_fields(8'h69, 8'h09, 5'd8, 4'd4);
    send_fields(8'h00, 8'h00, 5'd16, 4'd8);
    send_fields(8'hff, 8'hff, 5'd0, 4'd0);
    send_fields(8'h00, 8'hff, 5'd17, 4'd9);
    send_fields(8'hff, 8'h00, 5'd31, 4'd15);
    repeat (5) send_fields(8'h5a, 8'ha5, 5'd0, 4'd0);
    repeat (6) send_fields(8'h33, 8'h00, 5'd16, 4'd8);
    send_fields(8'hcc, 8'h10, 5'd1, 4'd1);
    send_fields(8'h12, 8'h20, 5'd15, 4'd7);
    send_fields(8'h80, 8'h7f, 5'd20, 4'd12);
    send_fields(8'h7f, 8'h80, 5'd8, 4'd4);

    // random: runs of one shift direction so the accumulated offsets reach far
    while (requests_sent < NUM_REQUESTS) begin
      if (!long_done && requests_sent > 600) begin
        mode = SHIFT_UP;
        seg_len = 260;
        long_done = 1'b1;
      end else begin
        mode = shift_mode_t'($urandom_range(0, 2));
        seg_len = $urandom_range(5, 60);
      end
      repeat (seg_len) send_request(make_request(mode));
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
